// ===== design/omni_pkg.sv =====
// Package for the omni wheel mixer: fixed-point widths, the Q1.15 mixing
// coefficient and the lane type of the pipelined duty divider. No dependencies.
package omni_pkg;

    localparam int VEL_W      = 16;                 // Q3.12 command fields
    localparam int FRAC_BITS  = 12;                 // 1.0 in the command format
    localparam int PWM_W      = 8;                  // duty field width
    localparam int PWM_FULL   = 255;                // full-scale duty
    localparam int NUM_WHEELS = 4;

    localparam int COEF_Q15   = 23170;              // 0.70710678 in Q1.15
    localparam int COEF_W     = 16;
    localparam int COEF_SHIFT = 15;

    localparam int SUM_W  = VEL_W + 1;              // vel_x +/- vel_y
    localparam int PROD_W = 33;                     // coefficient times sum, with room to negate
    localparam int MIX_W  = PROD_W - COEF_SHIFT;    // signed wheel value after the floor shift
    localparam int MAG_W  = MIX_W - 1;              // wheel magnitude
    localparam int NUM_W  = MAG_W + PWM_W;          // magnitude times full-scale duty

    localparam int DIV_STEPS = PWM_W;               // one quotient bit per stage

    // Magnitude that stands for 1.0; smaller peaks do not stretch the duty.
    localparam logic [MAG_W-1:0] UNIT_MAG = MAG_W'(1 << FRAC_BITS);

    // One wheel's state inside the restoring divider.
    typedef struct packed {
        logic [MAG_W-1:0] rem;    // partial remainder, always below the divisor
        logic [PWM_W-1:0] lo;     // dividend bits not yet shifted in
        logic [PWM_W-1:0] quo;    // quotient bits produced so far
    } div_lane_t;

endpackage

// ===== design/omni_wheel_mixer_unit.sv =====
// Four-wheel omni X-drive mixer: velocity command in, four duty/direction pairs out.
// Depends on omni_pkg for widths, constants and the divider lane type.
//
// Usage:
//   A request is a body velocity command (vel_x, vel_y, turn_rate), signed Q3.12.
//   It is taken at a rising edge where start is high and busy is low. The block
//   is fully pipelined, so busy stays low and a new request may be issued on
//   every clock cycle.
//   Each request produces one result: a duty and a direction bit for each of
//   the wheels at 135, 45, -45 and -135 degrees. The result sits on the pwm_*
//   and dir_* ports for exactly one cycle while done is high, and is taken at
//   the edge that ends that cycle. The receiver has no way to stall the block.
//   The result passes through five arithmetic stages followed by an eight-stage
//   divider, one quotient bit per stage. Throughput is one request per clock
//   cycle.
//   Results leave in request order.
//   Reset (rst_n low, asynchronous) clears every valid bit in the pipeline, so
//   requests in flight are dropped and no done strobe follows. There is no
//   configuration and nothing else to initialize.
//   A wheel value of zero drives forward (dir = 0); a small negative value may
//   give a zero duty with dir = 1.
module omni_wheel_mixer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [omni_pkg::VEL_W-1:0]   vel_x,
    input  logic signed [omni_pkg::VEL_W-1:0]   vel_y,
    input  logic signed [omni_pkg::VEL_W-1:0]   turn_rate,
    output logic                                done,
    output logic        [omni_pkg::PWM_W-1:0]   pwm_front_left,
    output logic                                dir_front_left,
    output logic        [omni_pkg::PWM_W-1:0]   pwm_front_right,
    output logic                                dir_front_right,
    output logic        [omni_pkg::PWM_W-1:0]   pwm_rear_right,
    output logic                                dir_rear_right,
    output logic        [omni_pkg::PWM_W-1:0]   pwm_rear_left,
    output logic                                dir_rear_left
);
    import omni_pkg::*;

    // Wheel order used throughout: front left, front right, rear right, rear left.
    localparam int FL = 0;
    localparam int FR = 1;
    localparam int RR = 2;
    localparam int RL = 3;

    localparam logic signed [COEF_W-1:0] COEF_S     = COEF_W'(COEF_Q15);
    localparam logic        [NUM_W-1:0]  PWM_FULL_N = NUM_W'(PWM_FULL);

    // One shift-compare-subtract step of the restoring divider.
    function automatic div_lane_t div_step(input div_lane_t lane, input logic [MAG_W-1:0] den);
        logic [MAG_W:0] trial;
        div_lane_t      res;
        trial  = {lane.rem, lane.lo[PWM_W-1]};
        res.lo = {lane.lo[PWM_W-2:0], 1'b0};
        if (trial >= {1'b0, den})
        begin
            res.rem = MAG_W'(trial - {1'b0, den});
            res.quo = {lane.quo[PWM_W-2:0], 1'b1};
        end
        else
        begin
            res.rem = trial[MAG_W-1:0];
            res.quo = {lane.quo[PWM_W-2:0], 1'b0};
        end
        return res;
    endfunction

    logic req_accept;

    // Stage 1: the two distinct combinations of the planar command.
    // Every wheel sees +/-(vel_x + vel_y) or +/-(vel_x - vel_y).
    logic                     s1_valid_reg;
    logic signed [SUM_W-1:0]  s1_sum_reg, s1_sum_next;
    logic signed [SUM_W-1:0]  s1_dif_reg, s1_dif_next;
    logic signed [VEL_W-1:0]  s1_turn_reg;

    // Stage 2: both sums scaled by the coefficient, exact.
    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] s2_psum_reg, s2_psum_next;
    logic signed [PROD_W-1:0] s2_pdif_reg, s2_pdif_next;
    logic signed [VEL_W-1:0]  s2_turn_reg;

    // Stage 3: signed wheel values after the floor shift and the rotation term.
    logic                     s3_valid_reg;
    logic signed [MIX_W-1:0]  s3_mix_reg  [NUM_WHEELS];
    logic signed [MIX_W-1:0]  s3_mix_next [NUM_WHEELS];

    // Stage 4: magnitude and direction per wheel.
    logic                     s4_valid_reg;
    logic        [MAG_W-1:0]  s4_mag_reg  [NUM_WHEELS];
    logic        [MAG_W-1:0]  s4_mag_next [NUM_WHEELS];
    logic        [NUM_WHEELS-1:0] s4_dir_reg;

    // Stage 5: shared divisor (peak magnitude, never below 1.0) and dividends.
    logic                     s5_valid_reg;
    logic        [MAG_W-1:0]  s5_den_reg, s5_den_next;
    logic        [NUM_W-1:0]  s5_num_reg  [NUM_WHEELS];
    logic        [NUM_W-1:0]  s5_num_next [NUM_WHEELS];
    logic        [NUM_WHEELS-1:0] s5_dir_reg;

    // Divider: one stage per quotient bit, four lanes sharing one divisor.
    logic        [DIV_STEPS-1:0]  div_valid_reg;
    div_lane_t                    div_lane_reg  [DIV_STEPS][NUM_WHEELS];
    div_lane_t                    div_lane_next [DIV_STEPS][NUM_WHEELS];
    logic        [MAG_W-1:0]      div_den_reg   [DIV_STEPS];
    logic        [NUM_WHEELS-1:0] div_dir_reg   [DIV_STEPS];

    // Every stage moves on every cycle, so a request is never refused.
    assign busy       = 1'b0;
    assign req_accept = start && !busy;

    always_comb
    begin
        s1_sum_next  = SUM_W'(vel_x) + SUM_W'(vel_y);
        s1_dif_next  = SUM_W'(vel_x) - SUM_W'(vel_y);
        s2_psum_next = PROD_W'(s1_sum_reg) * PROD_W'(COEF_S);
        s2_pdif_next = PROD_W'(s1_dif_reg) * PROD_W'(COEF_S);
    end

    // The arithmetic right shift of the exact product is the floor division by
    // 2^15; the sign is applied before the shift so negative wheels floor too.
    always_comb
    begin
        logic signed [PROD_W-1:0] sel [NUM_WHEELS];
        sel[FL] = -s2_pdif_reg;
        sel[FR] =  s2_psum_reg;
        sel[RR] =  s2_pdif_reg;
        sel[RL] = -s2_psum_reg;
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            s3_mix_next[i] = $signed(sel[i][PROD_W-1:COEF_SHIFT]) + MIX_W'(s2_turn_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            s4_mag_next[i] = s3_mix_reg[i][MIX_W-1] ? MAG_W'(-s3_mix_reg[i])
                                                    : MAG_W'(s3_mix_reg[i]);
        end
    end

    // Peak of the four magnitudes and the 1.0 floor, then the scaled dividends.
    always_comb
    begin
        logic [MAG_W-1:0] peak_a;
        logic [MAG_W-1:0] peak_b;
        logic [MAG_W-1:0] peak;
        peak_a = (s4_mag_reg[FL] > s4_mag_reg[FR]) ? s4_mag_reg[FL] : s4_mag_reg[FR];
        peak_b = (s4_mag_reg[RR] > s4_mag_reg[RL]) ? s4_mag_reg[RR] : s4_mag_reg[RL];
        peak   = (peak_a > peak_b) ? peak_a : peak_b;
        s5_den_next = (peak > UNIT_MAG) ? peak : UNIT_MAG;
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            s5_num_next[i] = NUM_W'(s4_mag_reg[i]) * PWM_FULL_N;
        end
    end

    // The dividend is below 256 times the divisor, so its upper bits already
    // form a remainder smaller than the divisor and only eight steps remain.
    always_comb
    begin
        div_lane_t first;
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            first.rem = s5_num_reg[i][NUM_W-1:PWM_W];
            first.lo  = s5_num_reg[i][PWM_W-1:0];
            first.quo = '0;
            div_lane_next[0][i] = div_step(first, s5_den_reg);
        end
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            for (int i = 0; i < NUM_WHEELS; i++)
            begin
                div_lane_next[k][i] = div_step(div_lane_reg[k-1][i], div_den_reg[k-1]);
            end
        end
    end

    // Valid bits travel with the data and are the only state cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            div_valid_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= req_accept;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            div_valid_reg <= {div_valid_reg[DIV_STEPS-2:0], s5_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sum_reg  <= s1_sum_next;
        s1_dif_reg  <= s1_dif_next;
        s1_turn_reg <= turn_rate;
        s2_psum_reg <= s2_psum_next;
        s2_pdif_reg <= s2_pdif_next;
        s2_turn_reg <= s1_turn_reg;
        s5_den_reg  <= s5_den_next;
        s5_dir_reg  <= s4_dir_reg;
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            s3_mix_reg[i] <= s3_mix_next[i];
            s4_mag_reg[i] <= s4_mag_next[i];
            s4_dir_reg[i] <= s3_mix_reg[i][MIX_W-1];
            s5_num_reg[i] <= s5_num_next[i];
        end
        div_den_reg[0] <= s5_den_reg;
        div_dir_reg[0] <= s5_dir_reg;
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            div_den_reg[k] <= div_den_reg[k-1];
            div_dir_reg[k] <= div_dir_reg[k-1];
        end
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            for (int i = 0; i < NUM_WHEELS; i++)
            begin
                div_lane_reg[k][i] <= div_lane_next[k][i];
            end
        end
    end

    assign done            = div_valid_reg[DIV_STEPS-1];
    assign pwm_front_left  = div_lane_reg[DIV_STEPS-1][FL].quo;
    assign pwm_front_right = div_lane_reg[DIV_STEPS-1][FR].quo;
    assign pwm_rear_right  = div_lane_reg[DIV_STEPS-1][RR].quo;
    assign pwm_rear_left   = div_lane_reg[DIV_STEPS-1][RL].quo;
    assign dir_front_left  = div_dir_reg[DIV_STEPS-1][FL];
    assign dir_front_right = div_dir_reg[DIV_STEPS-1][FR];
    assign dir_rear_right  = div_dir_reg[DIV_STEPS-1][RR];
    assign dir_rear_left   = div_dir_reg[DIV_STEPS-1][RL];

    // The shared divisor must cover every wheel, or a quotient would overflow.
    assert property (@(posedge clk) disable iff (!rst_n)
        s5_valid_reg |-> (s5_num_reg[FL] < {s5_den_reg, {PWM_W{1'b0}}}) &&
                         (s5_num_reg[FR] < {s5_den_reg, {PWM_W{1'b0}}}) &&
                         (s5_num_reg[RR] < {s5_den_reg, {PWM_W{1'b0}}}) &&
                         (s5_num_reg[RL] < {s5_den_reg, {PWM_W{1'b0}}}))
        else $error("dividend exceeds the quotient range of the duty divider");

    // The divisor never drops below 1.0, so small commands are not stretched.
    assert property (@(posedge clk) disable iff (!rst_n)
        s5_valid_reg |-> (s5_den_reg >= UNIT_MAG))
        else $error("duty divisor below unit magnitude");

    // A done strobe is always the divider output of an item that left stage 5.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(s5_valid_reg, DIV_STEPS))
        else $error("done strobe without a matching item in the divider");

endmodule
